// ===== rtl/radix_digit_converter_assert.svh =====
// Assertion macros for the radix digit converter checker.
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RDC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RDC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rdc_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function of the radix digit converter.
package rdc_pkg;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] DEC_LIMIT   = 5'd10;

  localparam logic [CHAR_W-1:0] DIGIT_BASE  = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] DIGIT_LAST  = 7'd57;  // '9'
  localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd65;  // 'A'
  localparam logic [CHAR_W-1:0] LETTER_LAST = 7'd90;  // 'Z'

  // Divider status toward the sequencer.
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DEC_LIMIT) begin
      return DIGIT_BASE + d_ext;
    end else begin
      return LETTER_BASE + d_ext - CHAR_W'(DEC_LIMIT);
    end
  endfunction

endpackage

// ===== rtl/rdc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle by a narrow divisor.
module rdc_div #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [VALUE_BITS-1:0]      dividend_i,
  input  logic [rdc_pkg::RADIX_W-1:0] divisor_i,
  output rdc_pkg::div_stat_t         stat_o,
  output logic [VALUE_BITS-1:0]      quot_o,
  output logic [rdc_pkg::RADIX_W-1:0] rem_o
);
  import rdc_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_BITS);
  localparam logic [CntW-1:0] LastStep = CntW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  zero_q, zero_d;
  logic [RADIX_W:0]      trial;
  logic [RADIX_W:0]      diff;

  always_comb begin
    trial  = {rem_q, quot_q[VALUE_BITS-1]};
    diff   = trial - {1'b0, div_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      zero_d = 1'b0;
    end else if (busy_q) begin
      // Shift in the next dividend bit; subtract when it fits.
      quot_d = {quot_q[VALUE_BITS-2:0], ~diff[RADIX_W]};
      rem_d  = diff[RADIX_W] ? trial[RADIX_W-1:0] : diff[RADIX_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        zero_d = (quot_d == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign stat_o.done      = done_q;
  assign stat_o.quot_zero = zero_q;
  assign quot_o           = quot_q;
  assign rem_o            = rem_q;

endmodule

// ===== rtl/radix_digit_converter.sv =====
// Top level of the radix digit converter: value in, ASCII digits out, MSD first.
// Flow: each digit comes from the bit-serial divider; each digit word is then shown
//   by a store read followed by the output.
// Throughput: one value at a time; the next value is taken the cycle after the last digit.
// Reset: asynchronous, active low; clears control state and sets radix to 10.
module radix_digit_converter #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_RADIX  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rdc_pkg::RADIX_W-1:0] radix_i,
  // value input channel
  input  logic                        value_valid_i,
  output logic                        value_ready_o,
  input  logic [VALUE_BITS-1:0]       value_i,
  // digit output channel
  output logic                        digit_valid_o,
  input  logic                        digit_ready_i,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_digit_o
);
  import rdc_pkg::*;

  localparam int unsigned AddrW    = $clog2(VALUE_BITS);
  localparam int unsigned CntW     = $clog2(VALUE_BITS + 1);
  localparam int unsigned RadixTop = (1 << RADIX_W) - 1;
  localparam int unsigned SatMax   = (MAX_RADIX > RadixTop) ? RadixTop : MAX_RADIX;
  localparam int unsigned DigW     = ($clog2(MAX_RADIX) > RADIX_W) ? RADIX_W
                                                                   : $clog2(MAX_RADIX);
  localparam logic [RADIX_W-1:0] MaxBase = RADIX_W'(SatMax);
  localparam logic [CntW-1:0]    NMax    = CntW'(VALUE_BITS);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;  // wait for a value word
  localparam logic [1:0] StDiv  = 2'd1;  // divider peels off the digits one by one
  localparam logic [1:0] StRead = 2'd2;  // read the next digit from the store
  localparam logic [1:0] StShow = 2'd3;  // hold the digit word until taken

  logic [1:0]            state_q, state_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [RADIX_W-1:0]    base;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [AddrW-1:0]      idx_q, idx_d;
  logic                  last_q, last_d;
  logic [DigW-1:0]       dig_q;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_in;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;
  logic                  store_we;
  logic                  rd_en;

  // Digit store, least significant digit at address zero.
  logic [DigW-1:0]       store_q [VALUE_BITS];

  // Saturate the base into the legal range.
  always_comb begin
    priority if (radix_q < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_q > MaxBase) begin
      base = MaxBase;
    end else begin
      base = radix_q;
    end
  end

  rdc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_in),
    .divisor_i (base),
    .stat_o    (div_stat),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    last_d    = last_q;
    div_start = 1'b0;
    div_in    = div_quot;
    store_we  = 1'b0;
    rd_en     = 1'b0;
    unique case (state_q)
      StIdle: begin
        div_in = value_i;
        if (value_valid_i) begin
          div_start = 1'b1;
          cnt_d     = '0;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_stat.done) begin
          // Store the remainder as the next digit; stop once the quotient runs out or the store is full.
          store_we = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          if (div_stat.quot_zero || (cnt_d == NMax)) begin
            idx_d   = cnt_q[AddrW-1:0];
            state_d = StRead;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      StRead: begin
        rd_en   = 1'b1;
        last_d  = (idx_q == '0);
        state_d = StShow;
      end
      StShow: begin
        if (digit_ready_i) begin
          if (last_q) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = StRead;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      radix_q <= RADIX_RESET;
      cnt_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      if (cfg_valid_i) begin
        radix_q <= radix_i;
      end
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cnt_q[AddrW-1:0]] <= div_rem[DigW-1:0];
    end
    if (rd_en) begin
      dig_q <= store_q[idx_q];
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign value_ready_o = (state_q == StIdle);
  assign digit_valid_o = (state_q == StShow);
  assign digit_char_o  = ascii_of(RADIX_W'(dig_q));
  assign last_digit_o  = last_q;

endmodule

// ===== rtl/rdc_checker.sv =====
// Port-level checker for the radix digit converter, bound to the top level.
`include "radix_digit_converter_assert.svh"

module rdc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       value_valid_i,
  input logic                       value_ready_o,
  input logic                       digit_valid_o,
  input logic                       digit_ready_i,
  input logic [rdc_pkg::CHAR_W-1:0] digit_char_o,
  input logic                       last_digit_o
);
  import rdc_pkg::*;

  // A stalled digit word holds.
  `RDC_ASSERT_NEXT(a_digit_hold, digit_valid_o && !digit_ready_i,
                   digit_valid_o && $stable(digit_char_o) && $stable(last_digit_o),
                   "digit word changed while stalled")

  // Only digits and upper-case letters leave the block.
  `RDC_ASSERT_NOW(a_char_legal, digit_valid_o,
                  (digit_char_o >= DIGIT_BASE && digit_char_o <= DIGIT_LAST) ||
                  (digit_char_o >= LETTER_BASE && digit_char_o <= LETTER_LAST),
                  "digit word is not a digit character")

  // Ready for a value only with no digit pending.
  `RDC_ASSERT_NOW(a_idle_quiet, value_ready_o, !digit_valid_o,
                  "value ready while a digit is shown")

  // Drop ready once a value word is taken.
  `RDC_ASSERT_NEXT(a_busy_after_take, value_valid_i && value_ready_o, !value_ready_o,
                   "value ready right after a value was taken")

  // Return to idle right after the last digit is taken.
  `RDC_ASSERT_NEXT(a_idle_after_last, digit_valid_o && digit_ready_i && last_digit_o,
                   value_ready_o && !digit_valid_o,
                   "not idle after the last digit")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the radix digit converter: random and corner values, corner and random radices.
module tb_top;
  import rdc_pkg::*;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned BASE_FLOOR  = 2;
  localparam int unsigned BASE_CEIL   = 16;
  // Longest silent stretch: a 32-digit base-2 value plus a receiver
  // hold-off, taken several times over.
  localparam int unsigned QUIET_LIMIT = 8000;
  // Drain time after the last digit; covers the slowest conversion.
  localparam int unsigned DRAIN_WAIT  = 1200;
  // Receiver hold-off: its start, its repeat period and its length.
  localparam int unsigned HOLD_START  = 2000;
  localparam int unsigned HOLD_PERIOD = 20000;
  localparam int unsigned HOLD_LEN    = 500;

  // One pending word for the driver: either a radix write or a value.
  typedef struct {
    bit                 is_radix;
    logic [VALUE_W-1:0] word;
  } job_t;

  // One expected digit word.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } digit_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [RADIX_W-1:0]   radix_i       = 5'd10;
  logic                 value_valid_i = 1'b0;
  logic                 value_ready_o;
  logic [VALUE_W-1:0]   value_i       = '0;
  logic                 digit_valid_o;
  logic                 digit_ready_i = 1'b0;
  logic [CHAR_W-1:0]    digit_char_o;
  logic                 last_digit_o;

  job_t        pending_words[$];
  digit_t      expected_digits[$];
  logic [RADIX_W-1:0] radix_model;

  int unsigned values_sent;
  int unsigned values_done;
  int unsigned digits_checked;
  int unsigned radix_writes;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned cycle_count;
  int unsigned hold_left;

  radix_digit_converter #(
    .VALUE_BITS(VALUE_W),
    .MAX_RADIX (BASE_CEIL)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .radix_i      (radix_i),
    .value_valid_i(value_valid_i),
    .value_ready_o(value_ready_o),
    .value_i      (value_i),
    .digit_valid_o(digit_valid_o),
    .digit_ready_i(digit_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp the radix register into the usable range of bases.
  function automatic int unsigned base_of(input logic [RADIX_W-1:0] r);
    int unsigned rv;
    rv = 32'(r);
    if (rv < BASE_FLOOR) return BASE_FLOOR;
    if (rv > BASE_CEIL) return BASE_CEIL;
    return rv;
  endfunction

  // Split a value into digits and queue them, most significant first.
  function automatic void predict_digits(input logic [VALUE_W-1:0] v,
                                         input logic [RADIX_W-1:0] r);
    int unsigned        b;
    logic [VALUE_W-1:0] rest;
    logic [3:0]         found[$];
    digit_t             w;
    b    = base_of(r);
    rest = v;
    do begin
      found.push_back(4'(rest % b));
      rest = rest / b;
    end while (rest != 0);
    for (int k = found.size() - 1; k >= 0; k--) begin
      if (found[k] < 10) w.ch = CHAR_W'("0") + CHAR_W'(found[k]);
      else w.ch = CHAR_W'("A") + CHAR_W'(found[k]) - CHAR_W'(10);
      w.is_last = (k == 0);
      expected_digits.push_back(w);
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    $display("mismatch at digit %0d: %s", digits_checked, what);
  endtask

  task automatic push_value(input logic [VALUE_W-1:0] v);
    job_t j;
    j.is_radix = 1'b0;
    j.word     = v;
    pending_words.push_back(j);
  endtask

  task automatic push_radix(input logic [RADIX_W-1:0] r);
    job_t j;
    j.is_radix = 1'b1;
    j.word     = VALUE_W'(r);
    pending_words.push_back(j);
  endtask

  // Driver: feed words from the pending queue. Hold a radix write back until every
  // value sent so far has finished its last digit, so the block is idle for it.
  int unsigned gap_left;
  bit          calm_tx;
  always @(posedge clk_i or negedge rst_ni) begin
    bit   v_nxt;
    bit   c_nxt;
    job_t j;
    if (!rst_ni) begin
      value_valid_i <= 1'b0;
      cfg_valid_i   <= 1'b0;
    end else begin
      v_nxt = value_valid_i;
      c_nxt = cfg_valid_i;
      if (value_valid_i && value_ready_o) begin
        values_sent++;
        v_nxt = 1'b0;
        if ($urandom_range(0, 15) == 0) calm_tx = !calm_tx;
        gap_left = calm_tx ? 0 : $urandom_range(0, 7);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        radix_writes++;
        c_nxt = 1'b0;
      end
      if (!v_nxt && !c_nxt) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].is_radix || values_done == values_sent)) begin
          j = pending_words.pop_front();
          if (j.is_radix) begin
            radix_i <= j.word[RADIX_W-1:0];
            c_nxt = 1'b1;
          end else begin
            value_i <= j.word;
            v_nxt = 1'b1;
          end
        end
      end
      value_valid_i <= v_nxt;
      cfg_valid_i   <= c_nxt;
    end
  end

  // Receiver hold-off: drop ready for a long stretch now and then so the block
  // backs up and stalls its input while the driver keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_count <= 0;
      hold_left   <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= HOLD_START && (cycle_count - HOLD_START) % HOLD_PERIOD == 0)
        hold_left <= HOLD_LEN;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each digit word against the oldest expectation, track the
  // radix register, and predict the digits of each accepted value.
  int unsigned stall_left;
  bit          calm_rx;
  always @(posedge clk_i or negedge rst_ni) begin
    digit_t w;
    if (!rst_ni) begin
      digit_ready_i <= 1'b0;
      radix_model   = rdc_pkg::RADIX_RESET;
      values_done   <= 0;
    end else begin
      if (digit_valid_o && digit_ready_i) begin
        if (expected_digits.size() == 0) begin
          note_mismatch($sformatf("unexpected digit %02h last=%0b", digit_char_o,
                                  last_digit_o));
        end else begin
          w = expected_digits.pop_front();
          if (digit_char_o !== w.ch)
            note_mismatch($sformatf("char %02h, want %02h", digit_char_o, w.ch));
          if (last_digit_o !== w.is_last)
            note_mismatch($sformatf("last flag %0b, want %0b", last_digit_o, w.is_last));
        end
        digits_checked++;
        if (last_digit_o === 1'b1) values_done <= values_done + 1;
        if ($urandom_range(0, 19) == 0) calm_rx = !calm_rx;
        stall_left = calm_rx ? 0 : $urandom_range(0, 7);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (cfg_valid_i && cfg_ready_o) radix_model = radix_i;
      if (value_valid_i && value_ready_o) predict_digits(value_i, radix_model);
      digit_ready_i <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (value_valid_i && value_ready_o) || (digit_valid_o && digit_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("[radix_digit_converter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed corners first, then random phases with a fresh radix each.
  initial begin
    logic [RADIX_W-1:0] radix_corners[6];
    logic [RADIX_W-1:0] r;
    logic [63:0]        pw;
    int unsigned        b;
    int unsigned        n_items;
    radix_corners = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

    // Directed: decimal after reset, then the base extremes and the clamped radices.
    push_value(32'd0);
    push_value(32'd9);
    push_value(32'd10);
    push_value(32'hFFFF_FFFF);
    push_radix(5'd2);
    push_value(32'd0);
    push_value(32'd1);
    push_value(32'hFFFF_FFFF);
    push_value(32'h8000_0000);
    push_radix(5'd16);
    push_value(32'hFEDC_BA98);
    push_value(32'hABCD_EF01);
    push_value(32'd0);
    push_radix(5'd0);
    push_value(32'd5);
    push_radix(5'd1);
    push_value(32'd6);
    push_radix(5'd17);
    push_value(32'h0000_00FF);
    push_radix(5'd31);
    push_value(32'h00C0_FFEE);
    push_radix(5'd3);
    push_value(32'hFFFF_FFFF);
    push_value(32'd2);

    // Random: short values, full-width values, and some on digit-count boundaries.
    for (int ph = 0; ph < 16; ph++) begin
      r = (ph % 3 == 0) ? radix_corners[$urandom_range(0, 5)] : 5'($urandom_range(0, 31));
      push_radix(r);
      b = base_of(r);
      n_items = $urandom_range(24, 34);
      repeat (n_items) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_value($urandom_range(0, 255));
          4, 5, 6:    push_value($urandom);
          7, 8: begin
            pw = 1;
            repeat ($urandom_range(1, 31)) if (pw * b <= 64'hFFFF_FFFF) pw = pw * b;
            push_value(32'(pw - $urandom_range(0, 1)));
          end
          default:    push_value($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0);
        endcase
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the queue to empty, every digit to arrive, then a drain window.
    while (pending_words.size() != 0 || value_valid_i || cfg_valid_i) @(posedge clk_i);
    while (values_done != values_sent || expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("converted %0d values into %0d digit words across %0d radix writes",
             values_sent, digits_checked, radix_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[radix_digit_converter] OK");
    end else begin
      $display("[radix_digit_converter] ERROR");
    end
    $finish;
  end

endmodule
